// ----- rtl/tbfh_pkg.sv -----
// Shared types and constants for the triple-buffer frame handoff block.
package tbfh_pkg;

    localparam int DEFAULT_BUFFER_COUNT = 3;
    localparam int ACTION_W             = 3;
    localparam int STATUS_W             = 3;
    localparam int IDX_W                = 3;
    localparam int DATA_W               = 64;

    // Requests from the writer and the reader.
    typedef enum logic [ACTION_W-1:0] {
        ACT_BEGIN_WRITE  = 3'd0,
        ACT_END_WRITE    = 3'd1,
        ACT_CANCEL_WRITE = 3'd2,
        ACT_GET_FRAME    = 3'd3,
        ACT_RELEASE      = 3'd4
    } t_action;

    // Result codes reported with every transaction.
    typedef enum logic [STATUS_W-1:0] {
        STS_OK           = 3'd0,
        STS_WRITE_BUSY   = 3'd1,
        STS_NO_WRITE     = 3'd2,
        STS_NO_BUFFER    = 3'd3,
        STS_HOLDING      = 3'd4,
        STS_NO_NEW_FRAME = 3'd5,
        STS_NOT_READY    = 3'd6
    } t_status;

    // Ownership state of one frame buffer.
    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_WRITING = 2'd1,
        SLOT_READY   = 2'd2,
        SLOT_READING = 2'd3
    } t_slot_state;

    // Controller states.
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_REPORT
    } t_fsm;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

// ----- rtl/tbfh_if.sv -----
// Handshake interfaces for the request and result channels.
interface tbfh_in_if
    import tbfh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   timestamp;

    modport source (output valid, output action, output timestamp, input ready);
    modport sink   (input valid, input action, input timestamp, output ready);
endinterface

interface tbfh_out_if
    import tbfh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;
    logic [DATA_W-1:0]   frame_time;
    logic [DATA_W-1:0]   frame_number;
    logic                new_frame_pending;
    logic [DATA_W-1:0]   dropped_count;

    modport source (output valid, output status, output slot_index, output frame_time,
                    output frame_number, output new_frame_pending, output dropped_count,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input frame_time,
                    input frame_number, input new_frame_pending, input dropped_count,
                    output ready);
endinterface

// ----- rtl/triple_buffer_frame_handoff.sv -----
// Each request is captured, stepped and then reported into the result register;
// a stalled result holds the report step, and no new request is accepted before
// the previous one has been reported.
// The next request is accepted while the previous result waits to be taken.
// Reset (synchronous, active low) frees all buffers, clears both counters,
// the latest index and the open write and read, and empties the result register.
module triple_buffer_frame_handoff
    import tbfh_pkg::*;
#(
    parameter int BUFFER_COUNT = DEFAULT_BUFFER_COUNT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tbfh_in_if.sink      i_in,
    tbfh_out_if.source   o_out
);

    t_dp_cmd cmd;

    // Request sequencing and handshakes.
    tbfh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // Buffer bookkeeping and result payload.
    tbfh_dpath #(
        .BUFFER_COUNT (BUFFER_COUNT)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_action            (i_in.action),
        .i_timestamp         (i_in.timestamp),
        .o_status            (o_out.status),
        .o_slot_index        (o_out.slot_index),
        .o_frame_time        (o_out.frame_time),
        .o_frame_number      (o_out.frame_number),
        .o_new_frame_pending (o_out.new_frame_pending),
        .o_dropped_count     (o_out.dropped_count)
    );

endmodule

// ----- rtl/tbfh_ctrl.sv -----
// Controller state machine that sequences each request through the datapath.
module tbfh_ctrl
    import tbfh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_fsm r_state;
    t_fsm n_state;
    logic r_out_valid;
    logic n_out_valid;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: begin
                if (i_in_valid) n_state = FSM_EXEC;
            end
            FSM_EXEC: begin
                n_state = FSM_REPORT;
            end
            FSM_REPORT: begin
                if (!r_out_valid || i_out_ready) n_state = FSM_IDLE;
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.cap_in    = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            FSM_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
            end
            FSM_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            FSM_REPORT: begin
                o_cmd.load_out = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // The result register stays valid until its transaction completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= FSM_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/tbfh_dpath.sv -----
// Datapath holding buffer ownership, counters, frame stamps and the result register.
module tbfh_dpath
    import tbfh_pkg::*;
#(
    parameter int BUFFER_COUNT = DEFAULT_BUFFER_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [DATA_W-1:0]   i_timestamp,
    output logic [STATUS_W-1:0] o_status,
    output logic [IDX_W-1:0]    o_slot_index,
    output logic [DATA_W-1:0]   o_frame_time,
    output logic [DATA_W-1:0]   o_frame_number,
    output logic                o_new_frame_pending,
    output logic [DATA_W-1:0]   o_dropped_count
);

    localparam int SW = $clog2(BUFFER_COUNT);

    // Captured request.
    t_action           r_action;
    logic [DATA_W-1:0] r_timestamp;

    // Buffer ownership and handoff state.
    t_slot_state       r_slot [BUFFER_COUNT];
    t_slot_state       n_slot [BUFFER_COUNT];
    logic [SW-1:0]     r_latest, n_latest;
    logic [DATA_W-1:0] r_wcnt, n_wcnt;
    logic [DATA_W-1:0] r_rcnt, n_rcnt;
    logic              r_wr_act, n_wr_act;
    logic [SW-1:0]     r_wr_slot, n_wr_slot;
    logic              r_rd_act, n_rd_act;
    logic [SW-1:0]     r_rd_slot, n_rd_slot;
    logic [DATA_W-1:0] r_rd_num, n_rd_num;

    // Per-buffer frame stamps, written at the writer's buffer, read at the latest.
    logic [DATA_W-1:0] r_time [BUFFER_COUNT];
    logic [DATA_W-1:0] r_num  [BUFFER_COUNT];

    // Staged step result.
    t_status           r_res_status, n_res_status;
    logic [SW-1:0]     r_res_idx, n_res_idx;
    logic [DATA_W-1:0] r_res_time, n_res_time;
    logic [DATA_W-1:0] r_res_num, n_res_num;

    // Result register.
    t_status           r_out_status;
    logic [IDX_W-1:0]  r_out_idx;
    logic [DATA_W-1:0] r_out_time;
    logic [DATA_W-1:0] r_out_num;
    logic              r_out_pend;
    logic [DATA_W-1:0] r_out_drop;

    logic              pick_found;
    logic [SW-1:0]     pick_slot;
    logic              stamp_we;
    logic [DATA_W-1:0] wcnt_inc;
    logic              pending;

    assign wcnt_inc = r_wcnt + DATA_W'(1);
    assign pending  = r_wcnt > r_rcnt;

    // Priority pick for begin write: free non-latest, then free latest, then ready.
    always_comb begin
        pick_found = 1'b0;
        pick_slot  = '0;
        for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (!pick_found && SW'(i) != r_latest && r_slot[i] == SLOT_FREE) begin
                pick_found = 1'b1;
                pick_slot  = SW'(i);
            end
        end
        if (!pick_found && r_slot[r_latest] == SLOT_FREE) begin
            pick_found = 1'b1;
            pick_slot  = r_latest;
        end
        for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (!pick_found && r_slot[i] == SLOT_READY) begin
                pick_found = 1'b1;
                pick_slot  = SW'(i);
            end
        end
    end

    // One request step.
    always_comb begin
        n_slot       = r_slot;
        n_latest     = r_latest;
        n_wcnt       = r_wcnt;
        n_rcnt       = r_rcnt;
        n_wr_act     = r_wr_act;
        n_wr_slot    = r_wr_slot;
        n_rd_act     = r_rd_act;
        n_rd_slot    = r_rd_slot;
        n_rd_num     = r_rd_num;
        n_res_status = STS_OK;
        n_res_idx    = '0;
        n_res_time   = '0;
        n_res_num    = '0;
        stamp_we     = 1'b0;
        case (r_action)
            ACT_BEGIN_WRITE: begin
                if (r_wr_act) begin
                    n_res_status = STS_WRITE_BUSY;
                end else if (!pick_found) begin
                    n_res_status = STS_NO_BUFFER;
                end else begin
                    n_slot[pick_slot] = SLOT_WRITING;
                    n_wr_act          = 1'b1;
                    n_wr_slot         = pick_slot;
                    n_res_idx         = pick_slot;
                end
            end
            ACT_END_WRITE: begin
                if (!r_wr_act) begin
                    n_res_status = STS_NO_WRITE;
                end else begin
                    n_wr_act          = 1'b0;
                    n_wcnt            = wcnt_inc;
                    stamp_we          = 1'b1;
                    n_slot[r_wr_slot] = SLOT_READY;
                    n_latest          = r_wr_slot;
                    n_res_idx         = r_wr_slot;
                end
            end
            ACT_CANCEL_WRITE: begin
                if (!r_wr_act) begin
                    n_res_status = STS_NO_WRITE;
                end else begin
                    n_wr_act          = 1'b0;
                    n_slot[r_wr_slot] = SLOT_FREE;
                    n_res_idx         = r_wr_slot;
                end
            end
            ACT_GET_FRAME: begin
                if (r_rd_act) begin
                    n_res_status = STS_HOLDING;
                end else if (!pending) begin
                    n_res_status = STS_NO_NEW_FRAME;
                end else if (r_slot[r_latest] != SLOT_READY) begin
                    n_res_status = STS_NOT_READY;
                end else begin
                    n_slot[r_latest] = SLOT_READING;
                    n_rd_act         = 1'b1;
                    n_rd_slot        = r_latest;
                    n_rd_num         = r_num[r_latest];
                    n_res_idx        = r_latest;
                    n_res_time       = r_time[r_latest];
                    n_res_num        = r_num[r_latest];
                end
            end
            ACT_RELEASE: begin
                // Releasing with no frame held reports ok and changes nothing.
                if (r_rd_act) begin
                    n_rd_act          = 1'b0;
                    n_rcnt            = r_rd_num;
                    n_slot[r_rd_slot] = SLOT_FREE;
                    n_res_idx         = r_rd_slot;
                end
            end
            default: begin
                n_res_status = STS_OK;
            end
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_action    <= t_action'(i_action);
            r_timestamp <= i_timestamp;
        end
    end

    // Control state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUFFER_COUNT; i++) begin
                r_slot[i] <= SLOT_FREE;
            end
            r_latest  <= '0;
            r_wcnt    <= '0;
            r_rcnt    <= '0;
            r_wr_act  <= 1'b0;
            r_wr_slot <= '0;
            r_rd_act  <= 1'b0;
            r_rd_slot <= '0;
        end else if (i_cmd.exec) begin
            r_slot    <= n_slot;
            r_latest  <= n_latest;
            r_wcnt    <= n_wcnt;
            r_rcnt    <= n_rcnt;
            r_wr_act  <= n_wr_act;
            r_wr_slot <= n_wr_slot;
            r_rd_act  <= n_rd_act;
            r_rd_slot <= n_rd_slot;
        end
    end

    // Payload of the step: held frame number and staged result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd_num     <= n_rd_num;
            r_res_status <= n_res_status;
            r_res_idx    <= n_res_idx;
            r_res_time   <= n_res_time;
            r_res_num    <= n_res_num;
        end
    end

    // Frame stamps are written when a frame is published.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && stamp_we) begin
            r_time[r_wr_slot] <= r_timestamp;
            r_num[r_wr_slot]  <= wcnt_inc;
        end
    end

    // Result register, with the pending flag and drop count from the updated counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_idx    <= IDX_W'(r_res_idx);
            r_out_time   <= r_res_time;
            r_out_num    <= r_res_num;
            r_out_pend   <= pending;
            r_out_drop   <= pending ? (r_wcnt - r_rcnt - DATA_W'(1)) : '0;
        end
    end

    assign o_status            = r_out_status;
    assign o_slot_index        = r_out_idx;
    assign o_frame_time        = r_out_time;
    assign o_frame_number      = r_out_num;
    assign o_new_frame_pending = r_out_pend;
    assign o_dropped_count     = r_out_drop;

endmodule

// ----- rtl/tbfh_checker.sv -----
// Port-level checks for the frame handoff block, bound to the top level.
module tbfh_checker
    import tbfh_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_out_status,
    input logic                i_out_pending,
    input logic [DATA_W-1:0]   i_out_dropped
);

    // A stalled result keeps its status.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status))
        else $error("result changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Only defined status codes are reported.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_status <= STATUS_W'(STS_NOT_READY))
        else $error("undefined status code");

    // Without a pending frame nothing can have been dropped.
    a_drop_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_pending |-> i_out_dropped == '0)
        else $error("drop count without pending frame");

    // One request is worked on at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while one is in progress");

endmodule

bind triple_buffer_frame_handoff tbfh_checker u_tbfh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_status  (o_out.status),
    .i_out_pending (o_out.new_frame_pending),
    .i_out_dropped (o_out.dropped_count)
);
